FILE: hdl/lrupr_pkg.sv
package lrupr_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_W     = 16;
    localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W     = IDX_W;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int LIMIT_W    = RANK_W + 1;

    localparam int CFG_W      = 5;
    localparam int SLOT_W     = 4;
    localparam int EVPAGE_W   = 16;
    localparam int FAULT_W    = 16;
    localparam int OUT_BITS   = 1 + SLOT_W + 1 + EVPAGE_W + FAULT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(4);
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;
    localparam logic [RANK_W-1:0]  RANK_TOP  = RANK_W'(MAX_FRAMES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic               hit_found;
        logic [IDX_W-1:0]   hit_idx;
        logic [RANK_W-1:0]  hit_rank;
        logic               empty_found;
        logic [IDX_W-1:0]   empty_idx;
        logic [RANK_W-1:0]  max_rank;
        logic [IDX_W-1:0]   max_idx;
        logic [PAGE_W-1:0]  max_page;
    } scan_t;

    typedef struct packed {
        logic               apply;
        logic               clear;
        logic               fill;
        logic [IDX_W-1:0]   slot;
        logic [LIMIT_W-1:0] limit;
        logic [PAGE_W-1:0]  page;
    } upd_t;

endpackage

FILE: hdl/lrupr_cell.sv
module lrupr_cell
    import lrupr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  cell_idx,
    input  logic [CNT_W-1:0]  n_eff,
    input  logic [PAGE_W-1:0] req_page,
    input  logic              act_in,
    input  scan_t             carry_in,
    input  upd_t              upd,
    output logic              act_out,
    output scan_t             carry_out
);

    logic              valid_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              act_reg;
    scan_t             carry_reg;
    scan_t             carry_next;
    logic              in_range;
    logic              is_slot;

    assign in_range  = CNT_W'(cell_idx) < n_eff;
    assign is_slot   = upd.slot == cell_idx;
    assign act_out   = act_reg;
    assign carry_out = carry_reg;

    always_comb
    begin
        carry_next = carry_in;
        if (in_range)
        begin
            if (!carry_in.hit_found && valid_reg && page_reg == req_page)
            begin
                carry_next.hit_found = 1'b1;
                carry_next.hit_idx   = cell_idx;
                carry_next.hit_rank  = rank_reg;
            end
            if (!carry_in.empty_found && !valid_reg)
            begin
                carry_next.empty_found = 1'b1;
                carry_next.empty_idx   = cell_idx;
            end
            if (cell_idx == '0 || rank_reg > carry_in.max_rank)
            begin
                carry_next.max_rank = rank_reg;
                carry_next.max_idx  = cell_idx;
                carry_next.max_page = page_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act_in)
        begin
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else if (upd.apply)
        begin
            if (upd.clear)
            begin
                valid_reg <= 1'b0;
                rank_reg  <= '0;
            end
            else if (is_slot)
            begin
                rank_reg <= '0;
                if (upd.fill)
                begin
                    valid_reg <= 1'b1;
                end
            end
            else if (valid_reg && LIMIT_W'(rank_reg) < upd.limit && rank_reg != RANK_TOP)
            begin
                rank_reg <= rank_reg + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.apply)
        begin
            if (upd.clear)
            begin
                page_reg <= '0;
            end
            else if (upd.fill && is_slot)
            begin
                page_reg <= upd.page;
            end
        end
    end

endmodule

FILE: hdl/lru_page_replacement_core.sv
// LRU page replacement over a fully associative set of up to 16 frames. Each request beat
// (page in s_tdata, end of string on s_tlast) yields one result beat. A search token walks
// the row of frame cells one cell per cycle, then the result is registered once the output
// is free (waits on m_tready); the next request is taken while the previous result still
// waits. frames_in_use is written through cfg_we/cfg_wdata; the user must write it only
// while idle, which the block does not enforce. 0 acts as 1 and values above 16 act as 16.
// End of string clears all frames and the fault count after its result.
module lru_page_replacement_core
    import lrupr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PAGE_W-1:0]     s_tdata,   // page
    input  logic                  s_tlast,   // end_of_string
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // hit, frame_slot, evicted_valid,
                                             // evicted_page, fault_count, zero pad
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata  // frames_in_use
);

    ctrl_state_t           state_reg, state_next;
    logic [CFG_W-1:0]      cfg_reg;
    logic                  start_reg;
    logic [PAGE_W-1:0]     page_reg;
    logic                  eos_reg;
    logic [FAULT_W-1:0]    fault_reg;
    logic [FAULT_W-1:0]    fault_next;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic [CNT_W-1:0]      n_eff;
    logic                  accept;
    logic                  out_free;
    logic                  finish;
    logic                  res_hit;
    logic                  res_evict;
    logic [IDX_W-1:0]      res_slot;
    logic [EVPAGE_W-1:0]   res_evpage;
    upd_t                  upd;
    scan_t                 fin;

    logic                  act_w   [MAX_FRAMES];
    scan_t                 carry_w [MAX_FRAMES];

    assign accept   = s_tvalid && s_tready;
    assign s_tready = state_reg == ST_IDLE;
    assign out_free = !out_valid_reg || m_tready;
    assign finish   = state_reg == ST_FINISH && out_free;
    assign fin      = carry_w[MAX_FRAMES-1];
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (int'(cfg_reg) > MAX_FRAMES)
        begin
            n_eff = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            n_eff = CNT_W'(cfg_reg);
        end
    end

    for (genvar i = 0; i < MAX_FRAMES; i++)
    begin : g_cell
        logic  act_in;
        scan_t carry_in;
        if (i == 0)
        begin : g_head
            assign act_in   = start_reg;
            assign carry_in = '0;
        end
        else
        begin : g_link
            assign act_in   = act_w[i-1];
            assign carry_in = carry_w[i-1];
        end
        lrupr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (IDX_W'(i)),
            .n_eff     (n_eff),
            .req_page  (page_reg),
            .act_in    (act_in),
            .carry_in  (carry_in),
            .upd       (upd),
            .act_out   (act_w[i]),
            .carry_out (carry_w[i])
        );
    end

    always_comb
    begin
        res_hit    = fin.hit_found;
        res_evict  = !fin.hit_found && !fin.empty_found;
        res_evpage = '0;
        upd.apply  = finish;
        upd.clear  = eos_reg;
        upd.page   = page_reg;
        upd.fill   = !fin.hit_found;
        if (fin.hit_found)
        begin
            res_slot  = fin.hit_idx;
            upd.limit = LIMIT_W'(fin.hit_rank);
        end
        else if (fin.empty_found)
        begin
            res_slot  = fin.empty_idx;
            upd.limit = LIMIT_W'(MAX_FRAMES);
        end
        else
        begin
            res_slot   = fin.max_idx;
            upd.limit  = LIMIT_W'(fin.max_rank);
            res_evpage = EVPAGE_W'(fin.max_page);
        end
        upd.slot = res_slot;

        if (res_hit || fault_reg == FAULT_MAX)
        begin
            fault_next = fault_reg;
        end
        else
        begin
            fault_next = fault_reg + FAULT_W'(1);
        end

        out_data_next = OUT_DATA_W'({fault_next, res_evpage, res_evict,
                                     SLOT_W'(res_slot), res_hit});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (act_w[MAX_FRAMES-1])
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= CFG_RESET;
            start_reg     <= 1'b0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (finish)
            begin
                fault_reg     <= eos_reg ? '0 : fault_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= s_tdata;
            eos_reg  <= s_tlast;
        end
        if (finish)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

FILE: hdl/lrupr_chk.sv
module lrupr_chk
    import lrupr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one still in search");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[5]))
        else $error("hit reported together with eviction");

    a_evpage_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[5] |-> m_tdata[21:6] == '0)
        else $error("evicted page nonzero without eviction");

    a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[37:22] != '0)
        else $error("fault reported with zero fault count");

endmodule

bind lru_page_replacement_core lrupr_chk u_lrupr_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/lru_replacement_checker.sv
module lru_replacement_checker
    import lrupr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [PAGE_W-1:0]     s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output int                    mismatch_count,
    output int                    lookups_pending
);

    typedef struct packed {
        logic [FAULT_W-1:0]  fault_count;
        logic [EVPAGE_W-1:0] evicted_page;
        logic                evicted_valid;
        logic [SLOT_W-1:0]   frame_slot;
        logic                hit;
    } lookup_t;

    logic              frame_used [MAX_FRAMES];
    logic [PAGE_W-1:0] frame_pg   [MAX_FRAMES];
    logic [RANK_W-1:0] frame_age  [MAX_FRAMES];
    logic [FAULT_W-1:0] faults;
    logic [CFG_W-1:0]  frames_cfg;
    lookup_t           expected_lookups [$];
    lookup_t           want;
    lookup_t           got;

    task clear_frames;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            frame_used[i] = 1'b0;
            frame_pg[i]   = '0;
            frame_age[i]  = '0;
        end
        faults = '0;
    endtask

    // make frame f most recent; valid frames younger than limit grow older
    task age_others(input int f, input int limit);
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (i != f && frame_used[i] && frame_age[i] < limit && frame_age[i] < RANK_TOP)
                frame_age[i] = frame_age[i] + 1'b1;
        end
        frame_age[f] = '0;
    endtask

    task serve_page_request(input logic [PAGE_W-1:0] page, input logic eos,
                            output lookup_t r);
        int   n;
        int   slot;
        int   oldest;
        logic hit;
        logic empty;
        n     = frames_cfg;
        slot  = 0;
        hit   = 1'b0;
        empty = 1'b0;
        r     = '0;
        if (n < 1)
            n = 1;
        if (n > MAX_FRAMES)
            n = MAX_FRAMES;
        for (int i = 0; i < n; i++)
        begin
            if (!hit && frame_used[i] && frame_pg[i] == page)
            begin
                hit  = 1'b1;
                slot = i;
            end
        end
        if (hit)
            age_others(slot, frame_age[slot]);
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                if (!empty && !frame_used[i])
                begin
                    empty = 1'b1;
                    slot  = i;
                end
            end
            if (empty)
            begin
                frame_used[slot] = 1'b1;
                frame_pg[slot]   = page;
                age_others(slot, MAX_FRAMES);
            end
            else
            begin
                oldest = frame_age[0];
                slot   = 0;
                for (int i = 1; i < n; i++)
                begin
                    if (frame_age[i] > oldest)
                    begin
                        oldest = frame_age[i];
                        slot   = i;
                    end
                end
                r.evicted_valid = 1'b1;
                r.evicted_page  = frame_pg[slot];
                frame_pg[slot]  = page;
                age_others(slot, oldest);
            end
            if (faults != FAULT_MAX)
                faults = faults + 1'b1;
        end
        r.hit         = hit;
        r.frame_slot  = slot[SLOT_W-1:0];
        r.fault_count = faults;
        if (eos)
            clear_frames();
    endtask

    task report(input string field, input logic [31:0] expected_val,
                input logic [31:0] actual_val);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t: %s mismatch: expected %0h, got %0h",
                     $realtime, field, expected_val, actual_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frames();
            frames_cfg = CFG_RESET;
            expected_lookups.delete();
            lookups_pending = 0;
            mismatch_count  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = lookup_t'(m_tdata[OUT_BITS-1:0]);
                if (expected_lookups.size() == 0)
                    report("unrequested result beat", '0, got.frame_slot);
                else
                begin
                    want = expected_lookups.pop_front();
                    if (got.hit !== want.hit)
                        report("hit", want.hit, got.hit);
                    if (got.frame_slot !== want.frame_slot)
                        report("frame_slot", want.frame_slot, got.frame_slot);
                    if (got.evicted_valid !== want.evicted_valid)
                        report("evicted_valid", want.evicted_valid, got.evicted_valid);
                    if (got.evicted_page !== want.evicted_page)
                        report("evicted_page", want.evicted_page, got.evicted_page);
                    if (got.fault_count !== want.fault_count)
                        report("fault_count", want.fault_count, got.fault_count);
                end
            end
            if (cfg_we)
                frames_cfg = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                serve_page_request(s_tdata, s_tlast, want);
                expected_lookups.push_back(want);
            end
            lookups_pending = expected_lookups.size();
        end
    end

endmodule

FILE: tb/tb_lru_page_replacement_core.sv
module tb_lru_page_replacement_core;
    import lrupr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PAGE_W-1:0]     s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    int   mismatches;
    int   pending;
    bit   rx_fast  = 1'b0;
    bit   rx_burst = 1'b0;
    bit   tx_fast  = 1'b0;
    bit   tx_burst = 1'b0;
    int   cur_frames = 4;

    lru_page_replacement_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    lru_replacement_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatches),
        .lookups_pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("lru_page_replacement_core verification failed");
        $finish;
    end

    // hold off the result side; two long stalls back up the request side
    initial
    begin : result_sink
        int w;
        int beats;
        beats = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (beats == 250 || beats == 900)
                w = 400;
            else if (rx_fast || rx_burst)
                w = 0;
            else
                w = $urandom_range(0, 12);
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            beats++;
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
        end
    end

    task automatic send_request(input logic [PAGE_W-1:0] page, input logic eos);
        int gap;
        gap = (tx_fast || tx_burst) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= page;
        s_tlast  <= eos;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (MAX_FRAMES + 4) @(posedge clk);
    endtask

    task automatic set_frames(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_frames = (value == 0) ? 1 : (value > MAX_FRAMES) ? MAX_FRAMES : value;
    endtask

    // strings over a small working set, with stray pages and early ends mixed in
    task automatic run_strings(input int count);
        logic [PAGE_W-1:0] ws_pages [20];
        int sent;
        int ws;
        int len;
        int r;
        logic [PAGE_W-1:0] page;
        logic eos;
        sent = 0;
        while (sent < count)
        begin
            ws = $urandom_range(1, cur_frames + 3);
            for (int i = 0; i < ws; i++)
                ws_pages[i] = PAGE_W'($urandom);
            len = $urandom_range(4, 60);
            tx_burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len && sent < count; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    page = ws_pages[$urandom_range(0, ws - 1)];
                else if (r < 95)
                    page = PAGE_W'($urandom);
                else
                    page = (r[0]) ? '1 : '0;
                if (k == len - 1)
                    eos = ($urandom_range(0, 3) != 0);
                else
                    eos = ($urandom_range(0, 99) == 0);
                send_request(page, eos);
                sent++;
            end
        end
        tx_burst = 1'b0;
    endtask

    initial
    begin : stimulus
        logic [CFG_W-1:0] phase_frames [8];
        phase_frames = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd2, 5'd17, 5'd8, 5'd0};
        phase_frames[7] = CFG_W'($urandom_range(0, 31));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'hAAAA, 1'b0);
        send_request(16'h5555, 1'b0);
        send_request(16'h1234, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h8001, 1'b1);
        send_request(16'h0101, 1'b0);
        send_request(16'h0202, 1'b0);
        send_request(16'h0303, 1'b0);
        send_request(16'h0404, 1'b0);
        drain();
        set_frames(5'd2);
        send_request(16'h0303, 1'b0);
        send_request(16'h0404, 1'b0);
        drain();
        set_frames(5'd4);
        send_request(16'h0303, 1'b0);
        send_request(16'h0404, 1'b0);
        send_request(16'h0202, 1'b0);
        send_request(16'h7FFF, 1'b1);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            set_frames(phase_frames[p]);
            run_strings(160);
            drain();
        end

        // one frame, back to back, distinct pages so each one after the first is a fault
        set_frames(5'd1);
        rx_fast = 1'b1;
        tx_fast = 1'b1;
        for (int k = 0; k < 99; k++)
            send_request(k[PAGE_W-1:0], (k == 98));
        send_request(16'h0001, 1'b0);
        tx_fast = 1'b0;
        rx_fast = 1'b0;
        drain();

        if (mismatches == 0 && pending == 0)
            $display("lru_page_replacement_core verification clean");
        else
            $display("lru_page_replacement_core verification failed");
        $finish;
    end

endmodule
